>>> rtl/core/snoop_bus_transaction_arbiter_defines.svh
// ----------------------------------------------------------------------------
// Snoop bus arbiter assertion macros
// Shared property shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SNOOP_BUS_TRANSACTION_ARBITER_DEFINES_SVH
`define SNOOP_BUS_TRANSACTION_ARBITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sbta_pkg.sv
// ----------------------------------------------------------------------------
// sbta_pkg
// Sizes, codes, types and helpers shared by the snoop bus arbiter modules.
// ----------------------------------------------------------------------------
package sbta_pkg;

  localparam int PORTS         = 8;
  localparam int QUEUE_DEPTH   = 8;
  localparam int TRACK_ENTRIES = 8;

  localparam int PW        = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW       = $clog2(QUEUE_DEPTH + 1);
  localparam int TW        = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int CW        = $clog2(PORTS + 1);
  localparam int OW        = $clog2(PORTS);
  localparam int MEM_DEPTH = PORTS * QUEUE_DEPTH;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam int LFSR_W    = 16;
  localparam int DCW       = $clog2(LFSR_W + 1);

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Input actions.
  localparam logic [1:0] ACT_REQ  = 2'd0;
  localparam logic [1:0] ACT_RESP = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Message kinds.
  localparam logic [2:0] MK_READ_RESP  = 3'd4;
  localparam logic [2:0] MK_INVAL_RESP = 3'd6;

  // Result kinds.
  localparam logic [2:0] OK_SNOOP    = 3'd0;
  localparam logic [2:0] OK_RESPOND  = 3'd1;
  localparam logic [2:0] OK_REMOTE   = 3'd2;
  localparam logic [2:0] OK_RELEASE  = 3'd3;
  localparam logic [2:0] OK_DISCARD  = 3'd4;
  localparam logic [2:0] OK_SCHEDULE = 3'd5;
  localparam logic [2:0] OK_REJECT   = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_REMOTE_PORT  = 3'd0;
  localparam logic [2:0] CFG_REMOTE_FIRST = 3'd1;
  localparam logic [2:0] CFG_LINEAR       = 3'd2;
  localparam logic [2:0] CFG_TRANSFER_LAT = 3'd3;
  localparam logic [2:0] CFG_BYTE_LAT     = 3'd4;

  typedef struct packed {
    logic [2:0]  remote_port;
    logic        remote_first;
    logic        linear;
    logic [15:0] transfer_lat;
    logic [7:0]  byte_lat;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  dest;
    logic [15:0] tag;
    logic [31:0] addr;
    logic [2:0]  mk;
    logic [16:0] delay;
  } res_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  kind;
    logic [15:0] tag;
  } qent_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REJECT,
    CMD_ENQ,
    CMD_RESP,
    CMD_SCAN_INIT,
    CMD_SCAN_STEP,
    CMD_SCAN_CHK,
    CMD_ATT_IDLE,
    CMD_PICK_REMOTE,
    CMD_LFSR_STEP,
    CMD_DIV_STEP,
    CMD_PICK_RAND,
    CMD_RD_HEAD,
    CMD_LATCH_HEAD,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_SHIFT_END,
    CMD_SNOOP,
    CMD_EMITQ,
    CMD_FLUSH
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       reject;
    logic       busy;
    logic       scan_done;
    logic       scan_rd;
    logic       att_none;
    logic       remote_pick;
    logic       div_last;
    logic       shift_more;
    logic       snoop_done;
    logic       rq_done;
    logic       emit_ok;
    logic       pend_v;
  } st_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [2:0] dest,
                                  input logic [15:0] tag, input logic [31:0] addr,
                                  input logic [2:0] mk, input logic [16:0] delay);
    res_t r;
    r.kind  = kind;
    r.dest  = dest;
    r.tag   = tag;
    r.addr  = addr;
    r.mk    = mk;
    r.delay = delay;
    return r;
  endfunction

  function automatic logic [MAW-1:0] qaddr(input logic [PW-1:0] p, input logic [QW-1:0] j);
    return MAW'(int'(p) * QUEUE_DEPTH + int'(j));
  endfunction

endpackage

>>> rtl/core/snoop_bus_transaction_arbiter.sv
// ----------------------------------------------------------------------------
// snoop_bus_transaction_arbiter
// Snoopy bus arbiter with per-port request queues and a transaction tracker.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Contents
//  in_      | input     | in_valid / in_ready  | request, response or attempt item
//  out_     | output    | out_valid / out_ready| result item, out_last on the final
//  cfg_     | input     | cfg_valid / cfg_ready| register index and write data
//
// A reject or response item stages its results and emits them in turn; a request
// or tick may go on to an attempt. An attempt scans every port's queue, checking
// queued entries against the tracker; a random choice uses a serial remainder
// unit, and a grant moves the queue entries up and sends the snoop copies.
// Reset is synchronous and active low; there is no clearing pass.
// A stalled result output holds the sequencer; config writes are always taken.
module snoop_bus_transaction_arbiter
  import sbta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_port,
  input  logic [2:0]  in_msg_kind,
  input  logic [31:0] in_addr,
  input  logic [7:0]  in_msg_size,
  input  logic        in_data_ok,
  input  logic [15:0] in_msg_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_dest_port,
  output logic [15:0] out_tag,
  output logic [31:0] out_addr,
  output logic [2:0]  out_msg_kind,
  output logic [16:0] out_delay,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;
  st_t  st;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.remote_port  <= 3'd0;
      cfg_r.remote_first <= 1'b1;
      cfg_r.linear       <= 1'b0;
      cfg_r.transfer_lat <= 16'd1;
      cfg_r.byte_lat     <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REMOTE_PORT:  cfg_r.remote_port  <= cfg_data[2:0];
        CFG_REMOTE_FIRST: cfg_r.remote_first <= cfg_data[0];
        CFG_LINEAR:       cfg_r.linear       <= cfg_data[0];
        CFG_TRANSFER_LAT: cfg_r.transfer_lat <= cfg_data;
        CFG_BYTE_LAT:     cfg_r.byte_lat     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sbta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sbta_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .st            (st),
    .in_action     (in_action),
    .in_port       (in_port),
    .in_msg_kind   (in_msg_kind),
    .in_addr       (in_addr),
    .in_msg_size   (in_msg_size),
    .in_data_ok    (in_data_ok),
    .in_msg_tag    (in_msg_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_dest_port (out_dest_port),
    .out_tag       (out_tag),
    .out_addr      (out_addr),
    .out_msg_kind  (out_msg_kind),
    .out_delay     (out_delay),
    .out_last      (out_last)
  );

endmodule

>>> rtl/core/sbta_ctrl.sv
// ----------------------------------------------------------------------------
// sbta_ctrl
// Sequencer that walks one item through enqueue, attempt and response steps.
// ----------------------------------------------------------------------------
module sbta_ctrl
  import sbta_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  st_t  st,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ATT_INIT, S_SCAN, S_SCAN_CHK, S_ATT_DEC, S_DIV, S_PICK,
    S_RD_HEAD, S_LATCH, S_SHIFT, S_SHIFT_WR, S_SNOOP, S_EMITQ, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.action)
          ACT_REQ: begin
            if (st.reject) begin
              cmd       = CMD_REJECT;
              state_nxt = S_EMITQ;
            end else begin
              cmd       = CMD_ENQ;
              state_nxt = st.busy ? S_FINISH : S_ATT_INIT;
            end
          end
          ACT_RESP: begin
            cmd       = CMD_RESP;
            state_nxt = S_EMITQ;
          end
          ACT_TICK: state_nxt = S_ATT_INIT;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_ATT_INIT: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = S_ATT_DEC;
        end else begin
          cmd = CMD_SCAN_STEP;
          if (st.scan_rd) state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd       = CMD_SCAN_CHK;
        state_nxt = S_SCAN;
      end
      S_ATT_DEC: begin
        if (st.att_none) begin
          cmd       = CMD_ATT_IDLE;
          state_nxt = S_FINISH;
        end else if (st.remote_pick) begin
          cmd       = CMD_PICK_REMOTE;
          state_nxt = S_RD_HEAD;
        end else begin
          cmd       = CMD_LFSR_STEP;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd = CMD_DIV_STEP;
        if (st.div_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd       = CMD_PICK_RAND;
        state_nxt = S_RD_HEAD;
      end
      S_RD_HEAD: begin
        cmd       = CMD_RD_HEAD;
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        cmd       = CMD_LATCH_HEAD;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (st.shift_more) begin
          cmd       = CMD_SHIFT_RD;
          state_nxt = S_SHIFT_WR;
        end else begin
          cmd       = CMD_SHIFT_END;
          state_nxt = S_SNOOP;
        end
      end
      S_SHIFT_WR: begin
        cmd       = CMD_SHIFT_WR;
        state_nxt = S_SHIFT;
      end
      S_SNOOP: begin
        if (st.snoop_done) state_nxt = S_FINISH;
        else if (st.emit_ok) cmd = CMD_SNOOP;
      end
      S_EMITQ: begin
        if (st.rq_done) state_nxt = S_FINISH;
        else if (st.emit_ok) cmd = CMD_EMITQ;
      end
      S_FINISH: begin
        if (!st.pend_v) begin
          state_nxt = S_IDLE;
        end else if (st.emit_ok) begin
          cmd       = CMD_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/sbta_dp.sv
// ----------------------------------------------------------------------------
// sbta_dp
// Port queues, transaction tracker, random pick and the result output stage.
// ----------------------------------------------------------------------------
`include "snoop_bus_transaction_arbiter_defines.svh"

module sbta_dp
  import sbta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output st_t         st,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_port,
  input  logic [2:0]  in_msg_kind,
  input  logic [31:0] in_addr,
  input  logic [7:0]  in_msg_size,
  input  logic        in_data_ok,
  input  logic [15:0] in_msg_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_dest_port,
  output logic [15:0] out_tag,
  output logic [31:0] out_addr,
  output logic [2:0]  out_msg_kind,
  output logic [16:0] out_delay,
  output logic        out_last
);

  // Latched item.
  logic [1:0]  ld_action_r;
  logic [2:0]  ld_port_r, ld_mk_r;
  logic [31:0] ld_addr_r;
  logic [7:0]  ld_size_r;
  logic        ld_ok_r;
  logic [15:0] ld_tag_r;

  // Queues.
  qent_t          qmem [MEM_DEPTH];
  qent_t          mem_rd_r;
  logic           mem_we, mem_re;
  logic [MAW-1:0] mem_wa, mem_ra;
  qent_t          mem_wd;
  logic [QCW-1:0] qcount_r [PORTS];

  // Tracker.
  logic [TRACK_ENTRIES-1:0] trk_valid_r;
  logic [31:0]              trk_addr_r [TRACK_ENTRIES];
  logic [OW-1:0]            trk_out_r  [TRACK_ENTRIES];
  logic [PW-1:0]            trk_req_r  [TRACK_ENTRIES];
  logic [15:0]              trk_tag_r  [TRACK_ENTRIES];
  logic [TRACK_ENTRIES-1:0] trk_sat_r;
  logic [1:0]               trk_kind_r [TRACK_ENTRIES];

  // Attempt state.
  logic             busy_r;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt, dvd_r;
  logic [CW-1:0]    scan_p_r, cnt_r, rem_r, snoop_i_r;
  logic [QCW-1:0]   scan_j_r, sh_j_r;
  logic [PORTS-1:0] cand_r;
  logic [QW-1:0]    idx_r [PORTS];
  logic [PW-1:0]    ch_r, ch_pick, remote;
  logic [TW-1:0]    slot_r, free_idx, hit_idx;
  logic             slot_found, hit_any;
  logic [DCW-1:0]   dcnt_r;
  logic [31:0]      head_addr_r;
  logic [1:0]       head_kind_r;
  logic [15:0]      head_tag_r;
  logic [31:0]      cmp_addr;
  logic [CW:0]      div_tmp;
  logic [CW-1:0]    rem_nxt, pre;

  // Result staging.
  res_t       rq_r [3];
  res_t       rq_c [3];
  logic [1:0] rn_r, rn_c, rq_k_r;
  logic       rel_c;
  logic       sat2, oro;
  logic [OW-1:0] out2;
  logic [16:0]   delay_c;
  res_t       pend_r, out_r, emit_res;
  logic       pend_v_r, out_v_r, out_last_r, emit_en;

  assign remote = PW'(cfg.remote_port % PORTS);

  // Tracker lookup and free entry search.
  assign cmp_addr = (cmd == CMD_SCAN_CHK) ? mem_rd_r.addr : ld_addr_r;
  always_comb begin
    hit_any    = 1'b0;
    hit_idx    = '0;
    slot_found = 1'b0;
    free_idx   = '0;
    for (int t = TRACK_ENTRIES - 1; t >= 0; t--) begin
      if (trk_valid_r[t] && trk_addr_r[t] == cmp_addr) begin
        hit_any = 1'b1;
        hit_idx = TW'(t);
      end
      if (!trk_valid_r[t]) begin
        slot_found = 1'b1;
        free_idx   = TW'(t);
      end
    end
  end

  // Random choice: step, remainder and selection.
  assign lfsr_nxt = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_W-1:1]};
  assign div_tmp  = {rem_r, dvd_r[LFSR_W-1]};
  assign rem_nxt  = (div_tmp >= {1'b0, cnt_r}) ? CW'(div_tmp - {1'b0, cnt_r}) : CW'(div_tmp);

  always_comb begin
    pre     = '0;
    ch_pick = '0;
    for (int p = 0; p < PORTS; p++) begin
      if (cand_r[p] && pre == rem_r) ch_pick = PW'(p);
      if (cand_r[p]) pre = pre + 1'b1;
    end
  end

  // Response evaluation.
  assign delay_c = 17'(cfg.transfer_lat)
                 + (cfg.linear ? 17'(17'(ld_size_r) * 17'(cfg.byte_lat)) : 17'd0);
  assign sat2 = ((ld_mk_r == MK_READ_RESP) || (ld_mk_r == MK_INVAL_RESP)) && ld_ok_r;
  assign out2 = (trk_out_r[hit_idx] == '0) ? '0 : trk_out_r[hit_idx] - 1'b1;
  assign oro  = (out2 == OW'(1)) && (trk_req_r[hit_idx] != remote);

  always_comb begin
    res_t disc, resp1, sched, rel, rmt;
    disc  = mk_res(OK_DISCARD, 3'd0, ld_tag_r, ld_addr_r, ld_mk_r, 17'd0);
    resp1 = mk_res(OK_RESPOND, 3'(trk_req_r[hit_idx]), ld_tag_r, ld_addr_r, ld_mk_r, delay_c);
    sched = mk_res(OK_SCHEDULE, 3'd0, 16'd0, ld_addr_r, ld_mk_r, delay_c);
    rel   = mk_res(OK_RELEASE, 3'd0, trk_tag_r[hit_idx], trk_addr_r[hit_idx],
                   {1'b0, trk_kind_r[hit_idx]}, 17'd0);
    rmt   = mk_res(OK_REMOTE, 3'(remote), trk_tag_r[hit_idx], ld_addr_r,
                   {1'b0, trk_kind_r[hit_idx]}, 17'd0);
    rq_c[0] = disc;
    rq_c[1] = disc;
    rq_c[2] = disc;
    rn_c    = 2'd1;
    rel_c   = 1'b0;
    if (cmd == CMD_REJECT) begin
      rq_c[0] = mk_res(OK_REJECT, ld_port_r, ld_tag_r, ld_addr_r, ld_mk_r, 17'd0);
    end else if (!(hit_any && ld_mk_r[2])) begin
      rq_c[0] = disc;
    end else if (!trk_sat_r[hit_idx]) begin
      if (sat2) begin
        rq_c[0] = resp1;
        rq_c[1] = sched;
        rn_c    = 2'd2;
        if (out2 == '0 || oro) begin
          rq_c[2] = rel;
          rn_c    = 2'd3;
          rel_c   = 1'b1;
        end
      end else if (oro) begin
        rq_c[1] = rmt;
        rn_c    = 2'd2;
      end else if (out2 == '0) begin
        rq_c[0] = resp1;
        rq_c[1] = sched;
        rq_c[2] = rel;
        rn_c    = 2'd3;
        rel_c   = 1'b1;
      end
    end else if (out2 == '0 || oro) begin
      rq_c[1] = sched;
      rq_c[2] = rel;
      rn_c    = 2'd3;
      rel_c   = 1'b1;
    end
  end

  // Queue memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = qaddr(PW'(ld_port_r), QW'(qcount_r[PW'(ld_port_r)]));
    mem_wd = '{addr: ld_addr_r, kind: ld_mk_r[1:0], tag: ld_tag_r};
    mem_re = 1'b0;
    mem_ra = qaddr(scan_p_r[PW-1:0], QW'(scan_j_r));
    case (cmd)
      CMD_ENQ:       mem_we = 1'b1;
      CMD_SCAN_STEP: mem_re = (scan_j_r < qcount_r[scan_p_r[PW-1:0]]);
      CMD_RD_HEAD: begin
        mem_re = 1'b1;
        mem_ra = qaddr(ch_r, idx_r[ch_r]);
      end
      CMD_SHIFT_RD: begin
        mem_re = 1'b1;
        mem_ra = qaddr(ch_r, QW'(sh_j_r + 1'b1));
      end
      CMD_SHIFT_WR: begin
        mem_we = 1'b1;
        mem_wa = qaddr(ch_r, QW'(sh_j_r));
        mem_wd = mem_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) qmem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_r <= qmem[mem_ra];
  end

  // Result emission: the newest result waits in pend until the next one or
  // the end of the item tells whether it is the last.
  always_comb begin
    emit_en  = 1'b0;
    emit_res = rq_r[rq_k_r];
    case (cmd)
      CMD_EMITQ: emit_en = 1'b1;
      CMD_SNOOP: begin
        emit_en  = (snoop_i_r != CW'(ch_r)) && (snoop_i_r != CW'(remote));
        emit_res = mk_res(OK_SNOOP, 3'(snoop_i_r), head_tag_r, head_addr_r,
                          {1'b0, head_kind_r}, 17'd0);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PORTS; p++) qcount_r[p] <= '0;
      trk_valid_r <= '0;
      busy_r      <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      if (emit_en) begin
        if (pend_v_r) out_v_r <= 1'b1;
        pend_v_r <= 1'b1;
      end
      case (cmd)
        CMD_ENQ: qcount_r[PW'(ld_port_r)] <= qcount_r[PW'(ld_port_r)] + 1'b1;
        CMD_RESP: begin
          if (hit_any && ld_mk_r[2] && rel_c) trk_valid_r[hit_idx] <= 1'b0;
        end
        CMD_ATT_IDLE:    busy_r <= 1'b0;
        CMD_PICK_REMOTE: busy_r <= 1'b1;
        CMD_LFSR_STEP: begin
          busy_r <= 1'b1;
          lfsr_r <= lfsr_nxt;
        end
        CMD_SHIFT_END: begin
          qcount_r[ch_r]      <= qcount_r[ch_r] - 1'b1;
          trk_valid_r[slot_r] <= 1'b1;
        end
        CMD_FLUSH: begin
          out_v_r  <= 1'b1;
          pend_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (emit_en) begin
      if (pend_v_r) begin
        out_r      <= pend_r;
        out_last_r <= 1'b0;
      end
      pend_r <= emit_res;
    end
    case (cmd)
      CMD_LOAD: begin
        ld_action_r <= in_action;
        ld_port_r   <= in_port;
        ld_mk_r     <= in_msg_kind;
        ld_addr_r   <= in_addr;
        ld_size_r   <= in_msg_size;
        ld_ok_r     <= in_data_ok;
        ld_tag_r    <= in_msg_tag;
      end
      CMD_REJECT: begin
        rq_r   <= rq_c;
        rn_r   <= 2'd1;
        rq_k_r <= 2'd0;
      end
      CMD_RESP: begin
        rq_r   <= rq_c;
        rn_r   <= rn_c;
        rq_k_r <= 2'd0;
        if (hit_any && ld_mk_r[2]) begin
          trk_sat_r[hit_idx] <= trk_sat_r[hit_idx] | sat2;
          trk_out_r[hit_idx] <= out2;
        end
      end
      CMD_EMITQ: rq_k_r <= rq_k_r + 1'b1;
      CMD_SCAN_INIT: begin
        scan_p_r <= '0;
        scan_j_r <= '0;
        cand_r   <= '0;
        cnt_r    <= '0;
      end
      CMD_SCAN_STEP: begin
        if (!(scan_j_r < qcount_r[scan_p_r[PW-1:0]])) begin
          scan_p_r <= scan_p_r + 1'b1;
          scan_j_r <= '0;
        end
      end
      CMD_SCAN_CHK: begin
        if (!hit_any) begin
          cand_r[scan_p_r[PW-1:0]] <= 1'b1;
          idx_r[scan_p_r[PW-1:0]]  <= QW'(scan_j_r);
          cnt_r    <= cnt_r + 1'b1;
          scan_p_r <= scan_p_r + 1'b1;
          scan_j_r <= '0;
        end else begin
          scan_j_r <= scan_j_r + 1'b1;
        end
      end
      CMD_PICK_REMOTE: begin
        ch_r   <= remote;
        slot_r <= free_idx;
      end
      CMD_LFSR_STEP: begin
        slot_r <= free_idx;
        dvd_r  <= lfsr_nxt;
        rem_r  <= '0;
        dcnt_r <= DCW'(LFSR_W);
      end
      CMD_DIV_STEP: begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[LFSR_W-2:0], 1'b0};
        dcnt_r <= dcnt_r - 1'b1;
      end
      CMD_PICK_RAND: ch_r <= ch_pick;
      CMD_RD_HEAD:   sh_j_r <= QCW'(idx_r[ch_r]);
      CMD_LATCH_HEAD: begin
        head_addr_r <= mem_rd_r.addr;
        head_kind_r <= mem_rd_r.kind;
        head_tag_r  <= mem_rd_r.tag;
      end
      CMD_SHIFT_WR: sh_j_r <= sh_j_r + 1'b1;
      CMD_SHIFT_END: begin
        trk_addr_r[slot_r] <= head_addr_r;
        trk_out_r[slot_r]  <= OW'(PORTS - 1);
        trk_req_r[slot_r]  <= ch_r;
        trk_tag_r[slot_r]  <= head_tag_r;
        trk_sat_r[slot_r]  <= 1'b0;
        trk_kind_r[slot_r] <= head_kind_r;
        snoop_i_r          <= '0;
      end
      CMD_SNOOP: snoop_i_r <= snoop_i_r + 1'b1;
      CMD_FLUSH: begin
        out_r      <= pend_r;
        out_last_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Status to the sequencer.
  always_comb begin
    st.action      = ld_action_r;
    st.reject      = (int'(ld_port_r) >= PORTS) || ld_mk_r[2]
                   || (qcount_r[PW'(ld_port_r)] == QCW'(QUEUE_DEPTH));
    st.busy        = busy_r;
    st.scan_done   = (scan_p_r == CW'(PORTS));
    st.scan_rd     = (scan_j_r < qcount_r[scan_p_r[PW-1:0]]);
    st.att_none    = (cnt_r == '0) || !slot_found;
    st.remote_pick = cfg.remote_first && cand_r[remote];
    st.div_last    = (dcnt_r == DCW'(1));
    st.shift_more  = ((sh_j_r + 1'b1) < qcount_r[ch_r]);
    st.snoop_done  = (snoop_i_r == CW'(PORTS));
    st.rq_done     = (rq_k_r == rn_r);
    st.emit_ok     = !pend_v_r || !out_v_r || out_ready;
    st.pend_v      = pend_v_r;
  end

  assign out_valid     = out_v_r;
  assign out_kind      = out_r.kind;
  assign out_dest_port = out_r.dest;
  assign out_tag       = out_r.tag;
  assign out_addr      = out_r.addr;
  assign out_msg_kind  = out_r.mk;
  assign out_delay     = out_r.delay;
  assign out_last      = out_last_r;

  `SBTA_ASSERT_NOW(a_slot_free, cmd == CMD_SHIFT_END, !trk_valid_r[slot_r], "tracker slot taken")
  `SBTA_ASSERT_NEXT(a_resp_nonempty, cmd == CMD_RESP, rn_r != 2'd0, "response gave no result")
  `SBTA_ASSERT_NEXT(a_pick_cand, cmd == CMD_PICK_RAND, cand_r[ch_r], "picked port has no candidate")

endmodule

>>> tb/snoop_bus_transaction_arbiter_checker.sv
// ----------------------------------------------------------------------------
// Snoop bus arbiter result checker
// Watches the input, result and register channels, predicts every result of
// each accepted item and compares the result stream against the prediction.
// ----------------------------------------------------------------------------
module snoop_bus_transaction_arbiter_checker
  import sbta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_port,
  input  logic [2:0]  in_msg_kind,
  input  logic [31:0] in_addr,
  input  logic [7:0]  in_msg_size,
  input  logic        in_data_ok,
  input  logic [15:0] in_msg_tag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [2:0]  out_dest_port,
  input  logic [15:0] out_tag,
  input  logic [31:0] out_addr,
  input  logic [2:0]  out_msg_kind,
  input  logic [16:0] out_delay,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          grant_count,
  output int          random_pick_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    res_t res;
    logic last;
  } arb_result_t;

  cfg_t        cfg;
  qent_t       port_queue [PORTS][QUEUE_DEPTH];
  int          port_fill [PORTS];
  logic        trk_open [TRACK_ENTRIES];
  logic [31:0] trk_addr [TRACK_ENTRIES];
  int          trk_owed [TRACK_ENTRIES];
  logic [2:0]  trk_req [TRACK_ENTRIES];
  logic [15:0] trk_tag [TRACK_ENTRIES];
  logic        trk_done [TRACK_ENTRIES];
  logic [2:0]  trk_kind [TRACK_ENTRIES];
  logic        bus_held;
  logic [15:0] lfsr;
  arb_result_t expected_results [$];
  res_t        item_results [$];

  assign pending_count = expected_results.size();

  function automatic int open_entry(input logic [31:0] a);
    for (int t = 0; t < TRACK_ENTRIES; t++)
      if (trk_open[t] && trk_addr[t] == a) return t;
    return -1;
  endfunction

  function automatic void push(input logic [2:0] k, input logic [2:0] d, input logic [15:0] tg,
                               input logic [31:0] a, input logic [2:0] mk,
                               input logic [16:0] dl);
    if (item_results.size() < 16) item_results = {item_results, mk_res(k, d, tg, a, mk, dl)};
  endfunction

  function automatic void grant_bus();
    logic has [PORTS];
    int   pos [PORTS];
    int   count, slot, ch, sel;
    logic [2:0] r;
    qent_t e;
    count = 0;
    slot = -1;
    ch = 0;
    for (int t = TRACK_ENTRIES - 1; t >= 0; t--)
      if (!trk_open[t]) slot = t;
    for (int p = 0; p < PORTS; p++) begin
      has[p] = 1'b0;
      pos[p] = 0;
      for (int j = 0; j < port_fill[p]; j++)
        if (open_entry(port_queue[p][j].addr) < 0) begin
          has[p] = 1'b1;
          pos[p] = j;
          count++;
          break;
        end
    end
    if (count == 0 || slot < 0) begin
      bus_held = 1'b0;
      return;
    end
    bus_held = 1'b1;
    grant_count++;
    r = cfg.remote_port;
    if (cfg.remote_first && has[r]) begin
      ch = r;
    end else begin
      lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
      random_pick_count++;
      sel = int'(lfsr) % count;
      for (int p = 0; p < PORTS; p++)
        if (has[p]) begin
          if (sel == 0) begin
            ch = p;
            break;
          end
          sel--;
        end
    end
    e = port_queue[ch][pos[ch]];
    for (int j = pos[ch]; j + 1 < port_fill[ch]; j++) port_queue[ch][j] = port_queue[ch][j + 1];
    port_fill[ch]--;
    for (int i = 0; i < PORTS; i++)
      if (i != ch && i != r) push(OK_SNOOP, 3'(i), e.tag, e.addr, {1'b0, e.kind}, '0);
    trk_open[slot] = 1'b1;
    trk_addr[slot] = e.addr;
    trk_owed[slot] = PORTS - 1;
    trk_req[slot] = 3'(ch);
    trk_tag[slot] = e.tag;
    trk_done[slot] = 1'b0;
    trk_kind[slot] = {1'b0, e.kind};
  endfunction

  function automatic void release_entry(input int t);
    push(OK_RELEASE, '0, trk_tag[t], trk_addr[t], trk_kind[t], '0);
    trk_open[t] = 1'b0;
  endfunction

  function automatic void take_response(input logic [2:0] k, input logic [31:0] a,
                                        input logic [7:0] sz, input logic ok,
                                        input logic [15:0] tg);
    int t;
    logic [16:0] d;
    logic only_remote;
    t = (k >= 4) ? open_entry(a) : -1;
    d = 17'(cfg.transfer_lat);
    if (cfg.linear) d = 17'(32'(cfg.transfer_lat) + 32'(sz) * 32'(cfg.byte_lat));
    if (t < 0) begin
      push(OK_DISCARD, '0, tg, a, k, '0);
      return;
    end
    if (!trk_done[t]) begin
      if ((k == MK_READ_RESP || k == MK_INVAL_RESP) && ok) trk_done[t] = 1'b1;
      if (trk_owed[t] > 0) trk_owed[t]--;
      only_remote = trk_owed[t] == 1 && trk_req[t] != cfg.remote_port;
      if (trk_done[t]) begin
        push(OK_RESPOND, trk_req[t], tg, a, k, d);
        push(OK_SCHEDULE, '0, '0, a, k, d);
        if (trk_owed[t] == 0 || only_remote) release_entry(t);
      end else if (only_remote) begin
        push(OK_DISCARD, '0, tg, a, k, '0);
        push(OK_REMOTE, cfg.remote_port, trk_tag[t], a, trk_kind[t], '0);
      end else if (trk_owed[t] == 0) begin
        push(OK_RESPOND, trk_req[t], tg, a, k, d);
        push(OK_SCHEDULE, '0, '0, a, k, d);
        release_entry(t);
      end else begin
        push(OK_DISCARD, '0, tg, a, k, '0);
      end
    end else begin
      push(OK_DISCARD, '0, tg, a, k, '0);
      if (trk_owed[t] > 0) trk_owed[t]--;
      if (trk_owed[t] == 0 || (trk_owed[t] == 1 && trk_req[t] != cfg.remote_port)) begin
        push(OK_SCHEDULE, '0, '0, a, k, d);
        release_entry(t);
      end
    end
  endfunction

  function automatic void predict_item(input logic [1:0] act, input logic [2:0] p,
                                       input logic [2:0] k, input logic [31:0] a,
                                       input logic [7:0] sz, input logic ok,
                                       input logic [15:0] tg);
    arb_result_t x;
    item_results.delete();
    if (act == ACT_REQ) begin
      if (k >= 4 || port_fill[p] >= QUEUE_DEPTH) begin
        push(OK_REJECT, p, tg, a, k, '0);
      end else begin
        port_queue[p][port_fill[p]] = '{addr: a, kind: k[1:0], tag: tg};
        port_fill[p]++;
        if (!bus_held) grant_bus();
      end
    end else if (act == ACT_RESP) begin
      take_response(k, a, sz, ok, tg);
    end else if (act == ACT_TICK) begin
      grant_bus();
    end
    foreach (item_results[i]) begin
      x.res = item_results[i];
      x.last = (i == item_results.size() - 1);
      expected_results = {expected_results, x};
    end
  endfunction

  always @(posedge clk) begin
    arb_result_t want;
    if (!rst_n) begin
      cfg <= '{remote_port: 3'd0, remote_first: 1'b1, linear: 1'b0, transfer_lat: 16'd1,
               byte_lat: 8'd0};
      for (int p = 0; p < PORTS; p++) port_fill[p] = 0;
      for (int t = 0; t < TRACK_ENTRIES; t++) trk_open[t] = 1'b0;
      bus_held = 1'b0;
      lfsr = LFSR_SEED;
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
      grant_count = 0;
      random_pick_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REMOTE_PORT:  cfg.remote_port <= cfg_data[2:0];
          CFG_REMOTE_FIRST: cfg.remote_first <= cfg_data[0];
          CFG_LINEAR:       cfg.linear <= cfg_data[0];
          CFG_TRANSFER_LAT: cfg.transfer_lat <= cfg_data;
          CFG_BYTE_LAT:     cfg.byte_lat <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d tag=%h addr=%h", $time, out_kind,
                   out_tag, out_addr);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if ({want.res, want.last} !== {out_kind, out_dest_port, out_tag, out_addr,
                                         out_msg_kind, out_delay, out_last}) begin
            $display("%0t: mismatch expected kind=%0d dest=%0d tag=%h addr=%h mk=%0d delay=%0d last=%0b",
                     $time, want.res.kind, want.res.dest, want.res.tag, want.res.addr,
                     want.res.mk, want.res.delay, want.last);
            $display("%0t:          actual kind=%0d dest=%0d tag=%h addr=%h mk=%0d delay=%0d last=%0b",
                     $time, out_kind, out_dest_port, out_tag, out_addr, out_msg_kind,
                     out_delay, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Prediction follows result popping so a same-cycle item never races its own results.
      if (in_valid && in_ready)
        predict_item(in_action, in_port, in_msg_kind, in_addr, in_msg_size, in_data_ok,
                     in_msg_tag);
    end
  end
endmodule

>>> tb/snoop_bus_transaction_arbiter_tb.sv
// ----------------------------------------------------------------------------
// Snoop bus arbiter testbench
// Drives requests, responses and attempt ticks with random gaps and result
// stalls across several register settings; the checker judges every result.
// ----------------------------------------------------------------------------
module snoop_bus_transaction_arbiter_tb
  import sbta_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [2:0]  in_port = '0;
  logic [2:0]  in_msg_kind = '0;
  logic [31:0] in_addr = '0;
  logic [7:0]  in_msg_size = '0;
  logic        in_data_ok = 1'b0;
  logic [15:0] in_msg_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [2:0]  out_dest_port;
  logic [15:0] out_tag;
  logic [31:0] out_addr;
  logic [2:0]  out_msg_kind;
  logic [16:0] out_delay;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending_count, result_count, grant_count, random_pick_count;
  logic        calm = 1'b0;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  logic [31:0] addr_pool [4];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  snoop_bus_transaction_arbiter i_dut (.*);

  snoop_bus_transaction_arbiter_checker i_checker (.*);

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 23);

  // Stops the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Valid stays high after an accepted item until an idle cycle or a drain drops it,
  // so that a following item can go out in the very next cycle.
  task automatic send_item(input logic [1:0] act, input logic [2:0] p, input logic [2:0] k,
                           input logic [31:0] a, input logic [7:0] sz, input logic ok,
                           input logic [15:0] tg);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_port <= p;
    in_msg_kind <= k;
    in_addr <= a;
    in_msg_size <= sz;
    in_data_ok <= ok;
    in_msg_tag <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [2:0] rp, input logic rf, input logic lin,
                          input logic [15:0] tl, input logic [7:0] bl);
    drain();
    write_reg(CFG_REMOTE_PORT, 16'(rp));
    write_reg(CFG_REMOTE_FIRST, 16'(rf));
    write_reg(CFG_LINEAR, 16'(lin));
    write_reg(CFG_TRANSFER_LAT, tl);
    write_reg(CFG_BYTE_LAT, 16'(bl));
    cfg_valid <= 1'b0;
  endtask

  // A transaction: a request, then seven items, mostly responses from ports 0 to 6.
  task automatic bus_round(input logic [2:0] req);
    logic [31:0] a;
    logic [2:0]  rk;
    a = addr_pool[$urandom_range(3)];
    rk = 3'($urandom_range(3));
    send_item(ACT_REQ, req, rk, a, 8'($urandom), 1'($urandom), 16'($urandom));
    for (int i = 0; i < 7; i++) begin
      if ($urandom_range(9) == 0)
        send_item(2'($urandom_range(3)), 3'($urandom), 3'($urandom), $urandom, 8'($urandom),
                  1'($urandom), 16'($urandom));
      else
        send_item(ACT_RESP, 3'(i), 3'($urandom_range(4, 7)), a, 8'($urandom),
                  ($urandom_range(3) == 0), 16'($urandom));
    end
    if ($urandom_range(2) == 0) send_item(ACT_TICK, '0, '0, '0, '0, 1'b0, '0);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects, extremes, a full queue and a complete transaction.
    send_item(ACT_REQ, 3'd7, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1, 16'hFFFF);
    send_item(ACT_REQ, 3'd1, 3'd4, 32'h0, 8'h0, 1'b0, 16'h0);
    send_item(ACT_RESP, 3'd2, 3'd4, 32'h1234, 8'h10, 1'b1, 16'h5555);
    send_item(ACT_RESP, 3'd2, 3'd1, 32'h1234, 8'h10, 1'b1, 16'hAAAA);
    send_item(2'd3, 3'd5, 3'd2, 32'h77, 8'h1, 1'b1, 16'h1);
    for (int i = 0; i < 9; i++)
      send_item(ACT_REQ, 3'd3, 3'(i % 4), 32'(32'h100 + i), 8'(i), 1'b0, 16'(i));
    for (int i = 0; i < 8; i++)
      send_item(ACT_RESP, 3'(i), (i == 5) ? MK_READ_RESP : 3'd7, 32'h100, 8'hFF, i == 5,
                16'(16'h100 + i));
    send_item(ACT_TICK, '0, '0, '0, '0, 1'b0, '0);

    // Pause until everything predicted has come out.
    drain();
    set_regs(3'd7, 1'b0, 1'b1, 16'hFFFF, 8'hFF);
    calm = 1'b1;
    for (int n = 0; n < 4; n++) bus_round(3'($urandom));
    calm = 1'b0;
    set_regs(3'd3, 1'b1, 1'b1, 16'd0, 8'd1);
    for (int n = 0; n < 4; n++) bus_round(3'($urandom));
    set_regs(3'd0, 1'b0, 1'b0, 16'd0, 8'd0);
    while (items_sent < 90) begin
      if ($urandom_range(3) == 0)
        send_item(2'($urandom_range(3)), 3'($urandom), 3'($urandom), addr_pool[$urandom_range(3)],
                  8'($urandom), 1'($urandom), 16'($urandom));
      else
        bus_round(3'($urandom));
    end
    set_regs(3'($urandom), 1'b1, 1'b0, 16'($urandom), 8'($urandom));
    for (int n = 0; n < 2; n++) bus_round(3'($urandom));

    drain();
    $display("Sent %0d items, checked %0d results; %0d bus grants, %0d by random choice.",
             items_sent, result_count, grant_count, random_pick_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
